>>> rtl/lrfs_pkg.sv
package lrfs_pkg;

  // APB register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_W  = 12;

  localparam logic REG_PANEL_WIDTH  = 1'b0;
  localparam logic REG_PANEL_HEIGHT = 1'b1;

  localparam logic [REG_W-1:0] PANEL_WIDTH_RST  = REG_W'(240);
  localparam logic [REG_W-1:0] PANEL_HEIGHT_RST = REG_W'(320);

  // request / pull codes
  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_FILL    = 3'd1;
  localparam logic [2:0] ACT_PIXEL   = 3'd2;
  localparam logic [2:0] ACT_HLINE   = 3'd3;
  localparam logic [2:0] ACT_VLINE   = 3'd4;
  localparam logic [2:0] ACT_PATTERN = 3'd5;
  localparam logic [2:0] ACT_PULL    = 3'd6;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOB       = 2'd1;
  localparam logic [1:0] ST_BUSY      = 2'd2;
  localparam logic [1:0] ST_IDLE_PULL = 2'd3;

  // display commands
  localparam logic [7:0] CMD_COL_ADDR  = 8'h2A;
  localparam logic [7:0] CMD_PAGE_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WRITE = 8'h2C;

  // test pattern: four bars of fixed size
  localparam int PAT_W   = 60;
  localparam int PAT_H   = 320;
  localparam int PAT_H_W = $clog2(PAT_H + 1);

  localparam logic [15:0] BAR_X [4] = '{16'd0, 16'd60, 16'd120, 16'd180};
  localparam logic [15:0] BAR_COLOR [4] = '{16'hF800, 16'h07E0, 16'h001F, 16'hFFFF};

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_COL_CMD,
    PH_COL_DATA,
    PH_PAGE_CMD,
    PH_PAGE_DATA,
    PH_MEM_CMD,
    PH_PIXELS
  } phase_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [15:0] extent_w;
    logic [15:0] extent_h;
    logic [15:0] color;
  } in_item_t;

  typedef struct packed {
    logic       byte_valid;
    logic [7:0] spi_byte;
    logic       is_data;
    logic       frame_end;
    logic       seq_done;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] panel_width;
    logic [REG_W-1:0] panel_height;
  } cfg_regs_t;

endpackage

>>> rtl/lrfs_cfg.sv
module lrfs_cfg
  import lrfs_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_regs_t         cfg
);

  logic [REG_W-1:0] width_r;
  logic [REG_W-1:0] height_r;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= PANEL_WIDTH_RST;
      height_r <= PANEL_HEIGHT_RST;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_PANEL_WIDTH:  width_r  <= pwdata[REG_W-1:0];
        REG_PANEL_HEIGHT: height_r <= pwdata[REG_W-1:0];
        default:          width_r  <= width_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PANEL_WIDTH:  prdata = APB_DW'(width_r);
      REG_PANEL_HEIGHT: prdata = APB_DW'(height_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.panel_width  = width_r;
  assign cfg.panel_height = height_r;

endmodule

>>> rtl/lrfs_core.sv
module lrfs_core
  import lrfs_pkg::*;
#(
  parameter int MAX_SIDE = 2048
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      proc_en,
  input  in_item_t  item,
  input  cfg_regs_t cfg,
  output out_item_t res
);

  localparam int SIDE_W  = $clog2(MAX_SIDE + 1);
  localparam int EXT_W   = (SIDE_W > PAT_H_W) ? SIDE_W : PAT_H_W;
  localparam int PIX_MAX = (MAX_SIDE * MAX_SIDE > PAT_W * PAT_H) ?
                           MAX_SIDE * MAX_SIDE : PAT_W * PAT_H;
  localparam int BL_W    = $clog2(2 * PIX_MAX + 1);

  phase_t phase_r, phase_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic [15:0] win_x0_r, win_x0_nxt, win_y0_r, win_y0_nxt;
  logic [15:0] win_x1_r, win_x1_nxt, win_y1_r, win_y1_nxt;
  logic [15:0] color_r, color_nxt;
  logic        spm_r, spm_nxt;
  logic [1:0]  bar_r, bar_nxt;
  logic        run_r, run_nxt;
  logic        mul_pend_r;
  logic [BL_W-1:0]  bl_r, bl_dec;
  logic             bl_dec_en;
  logic [EXT_W-1:0] ext_w_r, ext_h_r;
  logic [2*EXT_W-1:0] prod;

  logic        is_req, is_pull, oob, fin_more, bl_zero, bl_dec_zero, last_idx;
  logic [16:0] pw, ph, x17, y17, sum_xw, sum_yh, sum_yw, fill_w, fill_h, line_w, line_h;

  logic             start_en;
  logic [15:0]      st_x, st_y, st_c;
  logic [EXT_W-1:0] st_w, st_h;

  function automatic logic [7:0] win_byte(input logic [15:0] a, input logic [15:0] b,
                                          input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = a[15:8];
      2'd1:    r = a[7:0];
      2'd2:    r = b[15:8];
      default: r = b[7:0];
    endcase
    return r;
  endfunction

  // panel size limited to the largest supported side
  assign pw = (17'(cfg.panel_width) > 17'(MAX_SIDE)) ? 17'(MAX_SIDE) : 17'(cfg.panel_width);
  assign ph = (17'(cfg.panel_height) > 17'(MAX_SIDE)) ? 17'(MAX_SIDE) : 17'(cfg.panel_height);

  assign x17    = 17'(item.x_pos);
  assign y17    = 17'(item.y_pos);
  assign sum_xw = x17 + 17'(item.extent_w);
  assign sum_yh = y17 + 17'(item.extent_h);
  assign sum_yw = y17 + 17'(item.extent_w);
  assign fill_w = (sum_xw > pw) ? pw - x17 : 17'(item.extent_w);
  assign fill_h = (sum_yh > ph) ? ph - y17 : 17'(item.extent_h);
  assign line_w = fill_w;
  assign line_h = (sum_yw > ph) ? ph - y17 : 17'(item.extent_w);
  assign oob    = (x17 >= pw) || (y17 >= ph);

  assign is_req      = proc_en && (item.action <= ACT_PATTERN);
  assign is_pull     = proc_en && (item.action == ACT_PULL);
  assign fin_more    = run_r && (bar_r != 2'd3);
  assign bl_zero     = (bl_r == '0);
  assign bl_dec      = bl_r - BL_W'(1);
  assign bl_dec_zero = (bl_dec == '0);
  assign last_idx    = (idx_r == 2'd3);
  assign prod        = ext_w_r * ext_h_r;

  // next phase
  always_comb begin
    phase_nxt = phase_r;
    if (is_req) begin
      if (phase_r == PH_IDLE) begin
        if (item.action == ACT_CLEAR || item.action == ACT_PATTERN || !oob) begin
          phase_nxt = PH_COL_CMD;
        end
      end
    end else if (is_pull) begin
      unique case (phase_r)
        PH_COL_CMD:   phase_nxt = PH_COL_DATA;
        PH_COL_DATA:  phase_nxt = last_idx ? PH_PAGE_CMD : PH_COL_DATA;
        PH_PAGE_CMD:  phase_nxt = PH_PAGE_DATA;
        PH_PAGE_DATA: phase_nxt = last_idx ? PH_MEM_CMD : PH_PAGE_DATA;
        PH_MEM_CMD: begin
          if (!bl_zero) phase_nxt = PH_PIXELS;
          else          phase_nxt = fin_more ? PH_COL_CMD : PH_IDLE;
        end
        PH_PIXELS: begin
          if (bl_zero || bl_dec_zero) phase_nxt = fin_more ? PH_COL_CMD : PH_IDLE;
        end
        default:      phase_nxt = PH_IDLE;
      endcase
    end
  end

  // result and datapath
  always_comb begin
    res        = '0;
    res.status = ST_OK;
    idx_nxt    = idx_r;
    spm_nxt    = spm_r;
    bar_nxt    = bar_r;
    run_nxt    = run_r;
    bl_dec_en  = 1'b0;
    start_en   = 1'b0;
    st_x       = item.x_pos;
    st_y       = item.y_pos;
    st_w       = EXT_W'(1);
    st_h       = EXT_W'(1);
    st_c       = item.color;

    if (is_req) begin
      if (phase_r != PH_IDLE) begin
        res.status = ST_BUSY;
      end else begin
        unique case (item.action)
          ACT_CLEAR: begin
            spm_nxt  = 1'b0;
            start_en = 1'b1;
            st_x     = '0;
            st_y     = '0;
            st_w     = EXT_W'(pw);
            st_h     = EXT_W'(ph);
          end
          ACT_PATTERN: begin
            spm_nxt  = 1'b0;
            run_nxt  = 1'b1;
            bar_nxt  = 2'd0;
            start_en = 1'b1;
            st_x     = BAR_X[0];
            st_y     = '0;
            st_w     = EXT_W'(PAT_W);
            st_h     = EXT_W'(PAT_H);
            st_c     = BAR_COLOR[0];
          end
          default: begin
            if (oob) begin
              res.status = ST_OOB;
            end else begin
              start_en = 1'b1;
              spm_nxt  = (item.action == ACT_PIXEL);
              case (item.action)
                ACT_FILL: begin
                  st_w = EXT_W'(fill_w);
                  st_h = EXT_W'(fill_h);
                end
                ACT_HLINE: st_w = EXT_W'(line_w);
                ACT_VLINE: st_h = EXT_W'(line_h);
                default:   st_w = EXT_W'(1);
              endcase
            end
          end
        endcase
      end
    end else if (is_pull) begin
      res.byte_valid = 1'b1;
      unique case (phase_r)
        PH_COL_CMD: begin
          res.spi_byte  = CMD_COL_ADDR;
          res.frame_end = 1'b1;
          idx_nxt       = '0;
        end
        PH_COL_DATA, PH_PAGE_DATA: begin
          res.spi_byte  = (phase_r == PH_COL_DATA) ? win_byte(win_x0_r, win_x1_r, idx_r)
                                                   : win_byte(win_y0_r, win_y1_r, idx_r);
          res.is_data   = 1'b1;
          res.frame_end = last_idx;
          idx_nxt       = idx_r + 2'd1;
        end
        PH_PAGE_CMD: begin
          res.spi_byte  = CMD_PAGE_ADDR;
          res.frame_end = 1'b1;
          idx_nxt       = '0;
        end
        PH_MEM_CMD: begin
          res.spi_byte  = CMD_MEM_WRITE;
          res.frame_end = 1'b1;
          idx_nxt       = '0;
        end
        PH_PIXELS: begin
          res.spi_byte  = bl_r[0] ? color_r[7:0] : color_r[15:8];
          res.is_data   = 1'b1;
          bl_dec_en     = !bl_zero;
          res.frame_end = spm_r || bl_zero || bl_dec_zero;
        end
        default: begin
          res.byte_valid = 1'b0;
          res.status     = ST_IDLE_PULL;
        end
      endcase

      // end of one window: next pattern bar or done
      if ((phase_r == PH_MEM_CMD && bl_zero) ||
          (phase_r == PH_PIXELS && (bl_zero || bl_dec_zero))) begin
        if (fin_more) begin
          bar_nxt  = bar_r + 2'd1;
          start_en = 1'b1;
          st_x     = BAR_X[bar_r + 2'd1];
          st_y     = '0;
          st_w     = EXT_W'(PAT_W);
          st_h     = EXT_W'(PAT_H);
          st_c     = BAR_COLOR[bar_r + 2'd1];
        end else begin
          run_nxt      = 1'b0;
          res.seq_done = 1'b1;
        end
      end
    end

    win_x0_nxt = win_x0_r;
    win_y0_nxt = win_y0_r;
    win_x1_nxt = win_x1_r;
    win_y1_nxt = win_y1_r;
    color_nxt  = color_r;
    if (start_en) begin
      win_x0_nxt = st_x;
      win_y0_nxt = st_y;
      win_x1_nxt = st_x + 16'(st_w) - 16'd1;
      win_y1_nxt = st_y + 16'(st_h) - 16'd1;
      color_nxt  = st_c;
      idx_nxt    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      idx_r      <= '0;
      spm_r      <= 1'b0;
      bar_r      <= '0;
      run_r      <= 1'b0;
      mul_pend_r <= 1'b0;
      bl_r       <= '0;
    end else begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      spm_r      <= spm_nxt;
      bar_r      <= bar_nxt;
      run_r      <= run_nxt;
      mul_pend_r <= start_en;
      // pixel byte count is loaded into bl_r once mul_pend_r marks the start; the window
      // header bytes always come first, so nothing reads it earlier
      if (mul_pend_r) begin
        bl_r <= BL_W'({prod, 1'b0});
      end else if (bl_dec_en) begin
        bl_r <= bl_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    win_x0_r <= win_x0_nxt;
    win_y0_r <= win_y0_nxt;
    win_x1_r <= win_x1_nxt;
    win_y1_r <= win_y1_nxt;
    color_r  <= color_nxt;
    if (start_en) begin
      ext_w_r <= st_w;
      ext_h_r <= st_h;
    end
  end

endmodule

>>> rtl/lcd_rect_fill_spi_sequencer.sv
// Channel  | Direction | Ports                                 | Transfer when
// ---------+-----------+---------------------------------------+------------------------
// input    | in        | in_valid, in_stall, in_data           | in_valid && !in_stall
// result   | out       | out_valid, out_stall, out_data        | out_valid && !out_stall
// config   | in        | psel, penable, pwrite, paddr, pwdata, | psel && penable &&
//          |           | prdata, pready                        | pwrite (pready high)
//
// One item per cycle sustained while out_stall stays low; every item gives one result,
// registered first in the input register, then in the result register. Sequencer state
// and the result are both formed combinationally from the input register.
// Synchronous reset returns the sequencer to idle and the panel size to 240 x 320.
// A stalled result register holds the input register, and in_stall rises only then.
module lcd_rect_fill_spi_sequencer
  import lrfs_pkg::*;
#(
  parameter int MAX_SIDE = 2048
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_data,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic      s1_v_r;
  in_item_t  s1_d_r;
  logic      out_v_r;
  out_item_t out_d_r;
  logic      out_adv, s1_adv;
  cfg_regs_t cfg;
  out_item_t res;

  assign out_adv   = !out_v_r || !out_stall;
  assign s1_adv    = s1_v_r && out_adv;
  assign in_stall  = s1_v_r && !out_adv;
  assign out_valid = out_v_r;
  assign out_data  = out_d_r;

  lrfs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lrfs_core #(
    .MAX_SIDE (MAX_SIDE)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .proc_en (s1_adv),
    .item    (s1_d_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (!in_stall) s1_v_r <= in_valid;
      if (out_adv)   out_v_r <= s1_v_r;
    end
  end

  // payload: take a transfer, hold while stalled
  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) s1_d_r <= in_data;
    if (s1_adv)                out_d_r <= res;
  end

endmodule
